// ===== hdl/lmps_pkg.sv =====
// ----------------------------------------------------------------------------
// lmps_pkg
// shared sizes, codes and types of the led matrix pwm scanner
// ----------------------------------------------------------------------------
package lmps_pkg;

    // matrix geometry and pwm range
    localparam int ROWS      = 6;
    localparam int COLS      = 16;
    localparam int LEVEL_MAX = 15;
    localparam int NLEDS     = ROWS * COLS;

    // lock led positions in row-major order
    localparam int POS_SCROLL = 80 + 3;
    localparam int POS_NUM    = 80 + 7;
    localparam int POS_CAPS   = 80 + 8;

    // rows that hold a lock led
    localparam int LOCK_ROW_FIRST = POS_SCROLL / COLS;
    localparam int LOCK_ROW_LAST  = POS_CAPS / COLS;

    localparam int BYTE_W     = 8;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ROW_BITS   = COLS * BYTE_W;
    localparam int OUT_ROW_W  = 3;
    localparam int OUT_MASK_W = 16;
    localparam int OP_W       = 2;
    localparam int FLAG_W     = 3;

    // lock flag bits
    localparam int FLAG_CAPS   = 0;
    localparam int FLAG_NUM    = 1;
    localparam int FLAG_SCROLL = 2;

    // request opcodes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_FADE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCK   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // small queues between the parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_FADE = 2'd1,
        CMD_LOCK = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [FLAG_W-1:0] flags;
    } cmd_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0]  row;
        logic [OUT_MASK_W-1:0] mask;
    } res_t;

endpackage

// ===== hdl/lmps_ram.sv =====
// ----------------------------------------------------------------------------
// lmps_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lmps_front.sv =====
// ----------------------------------------------------------------------------
// lmps_front
// accepts input requests, decodes the opcode and queues commands
// ----------------------------------------------------------------------------
module lmps_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [lmps_pkg::OP_W-1:0] opcode,
    input  logic                     caps_on,
    input  logic                     num_on,
    input  logic                     scroll_on,
    output logic                     cmd_valid,
    output lmps_pkg::cmd_t           cmd,
    input  logic                     cmd_ready
);

    lmps_pkg::cmd_t                    q_reg [lmps_pkg::QUEUE_DEPTH];
    logic [lmps_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [lmps_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [lmps_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              accept;
    logic                              known;
    logic                              q_push;
    logic                              q_pop;
    lmps_pkg::cmd_t                    dec_cmd;

    // opcode decode, the unused code is taken and dropped
    always_comb
    begin
        dec_cmd.kind  = lmps_pkg::CMD_TICK;
        dec_cmd.flags = {scroll_on, num_on, caps_on};
        known         = 1'b1;
        unique case (opcode)
            lmps_pkg::OP_TICK: dec_cmd.kind = lmps_pkg::CMD_TICK;
            lmps_pkg::OP_FADE: dec_cmd.kind = lmps_pkg::CMD_FADE;
            lmps_pkg::OP_LOCK: dec_cmd.kind = lmps_pkg::CMD_LOCK;
            default:           known = 1'b0;
        endcase
    end

    assign full      = (count_reg == lmps_pkg::QCNT_W'(lmps_pkg::QUEUE_DEPTH));
    assign accept    = push && !full;
    assign q_push    = accept && known;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign q_pop     = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push)
        begin
            wr_ptr_next = (wr_ptr_reg == lmps_pkg::QPTR_W'(lmps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lmps_pkg::QPTR_W'(lmps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (q_push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!q_push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

// ===== hdl/lmps_back.sv =====
// ----------------------------------------------------------------------------
// lmps_back
// executes commands: row scan, level fill, lock leds and fade over the
// row-wide brightness ram
// ----------------------------------------------------------------------------
module lmps_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lmps_pkg::BYTE_W-1:0] cfg_wdata,
    input  logic                        cmd_valid,
    input  lmps_pkg::cmd_t              cmd,
    output logic                        cmd_ready,
    output logic                        res_push,
    output lmps_pkg::res_t              res,
    input  logic                        res_space
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MASK = 4'b0010,
        ST_RD   = 4'b0100,
        ST_WR   = 4'b1000
    } state_t;

    state_t                             state_reg, state_next;
    logic [lmps_pkg::BYTE_W-1:0]        backlight_reg;
    logic [lmps_pkg::ROW_W-1:0]         scan_row_reg, scan_row_next;
    logic [lmps_pkg::BYTE_W-1:0]        phase_reg, phase_next;
    logic [lmps_pkg::BYTE_W-1:0]        applied_reg, applied_next;
    logic [lmps_pkg::FLAG_W-1:0]        flags_reg, flags_next;
    logic [lmps_pkg::ROW_W-1:0]         sweep_row_reg, sweep_row_next;
    logic [lmps_pkg::ROW_W-1:0]         sweep_last_reg, sweep_last_next;
    logic                               is_tick_reg, is_tick_next;
    logic                               fill_reg, fill_next;
    logic [lmps_pkg::ROWS-1:0]          row_valid_reg;
    logic                               rd_valid_reg;
    logic [lmps_pkg::BYTE_W-1:0]        level;
    logic [lmps_pkg::BYTE_W-1:0]        lock_on;

    logic                               ram_we;
    logic                               ram_re;
    logic [lmps_pkg::ROW_W-1:0]         ram_raddr;
    logic [lmps_pkg::ROW_BITS-1:0]      ram_rdata;
    logic [lmps_pkg::ROW_BITS-1:0]      row_data;
    logic [lmps_pkg::ROW_BITS-1:0]      row_new;
    logic [lmps_pkg::COLS-1:0]          mask_full;

    lmps_ram #(
        .WIDTH (lmps_pkg::ROW_BITS),
        .DEPTH (lmps_pkg::ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sweep_row_reg),
        .wdata (row_new),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign level   = (backlight_reg > lmps_pkg::BYTE_W'(lmps_pkg::LEVEL_MAX)) ?
                     lmps_pkg::BYTE_W'(lmps_pkg::LEVEL_MAX) : backlight_reg;
    assign lock_on = lmps_pkg::BYTE_W'(lmps_pkg::LEVEL_MAX);

    // rows never written still hold the reset brightness of one
    assign row_data = rd_valid_reg ? ram_rdata :
                      {lmps_pkg::COLS{lmps_pkg::BYTE_W'(1)}};

    // column compare against the pwm phase
    always_comb
    begin
        for (int c = 0; c < lmps_pkg::COLS; c++)
        begin
            mask_full[c] = (row_data[c*lmps_pkg::BYTE_W +: lmps_pkg::BYTE_W] > phase_reg);
        end
    end

    // new row contents for the sweep
    always_comb
    begin
        int                          pos;
        logic [lmps_pkg::BYTE_W-1:0] old_b;
        logic [lmps_pkg::BYTE_W-1:0] new_b;
        for (int c = 0; c < lmps_pkg::COLS; c++)
        begin
            pos   = int'(sweep_row_reg) * lmps_pkg::COLS + c;
            old_b = row_data[c*lmps_pkg::BYTE_W +: lmps_pkg::BYTE_W];
            new_b = old_b;
            if (is_tick_reg)
            begin
                if (pos == lmps_pkg::POS_CAPS)
                begin
                    new_b = flags_reg[lmps_pkg::FLAG_CAPS] ? lock_on : '0;
                end
                else if (pos == lmps_pkg::POS_NUM)
                begin
                    new_b = flags_reg[lmps_pkg::FLAG_NUM] ? lock_on : '0;
                end
                else if (pos == lmps_pkg::POS_SCROLL)
                begin
                    new_b = flags_reg[lmps_pkg::FLAG_SCROLL] ? lock_on : '0;
                end
                else if (fill_reg)
                begin
                    new_b = applied_reg;
                end
            end
            else if (old_b != '0)
            begin
                new_b = old_b - 1'b1;
            end
            row_new[c*lmps_pkg::BYTE_W +: lmps_pkg::BYTE_W] = new_b;
        end
    end

    assign res.row  = scan_row_reg[lmps_pkg::OUT_ROW_W-1:0];
    assign res.mask = mask_full[lmps_pkg::OUT_MASK_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        scan_row_next   = scan_row_reg;
        phase_next      = phase_reg;
        applied_next    = applied_reg;
        flags_next      = flags_reg;
        sweep_row_next  = sweep_row_reg;
        sweep_last_next = sweep_last_reg;
        is_tick_next    = is_tick_reg;
        fill_next       = fill_reg;
        cmd_ready       = 1'b0;
        res_push        = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = sweep_row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = (cmd.kind != lmps_pkg::CMD_TICK) || res_space;
                if (cmd_valid && cmd_ready)
                begin
                    case (cmd.kind)
                        lmps_pkg::CMD_TICK:
                        begin
                            ram_re       = 1'b1;
                            ram_raddr    = scan_row_reg;
                            is_tick_next = 1'b1;
                            state_next   = ST_MASK;
                        end
                        lmps_pkg::CMD_FADE:
                        begin
                            is_tick_next    = 1'b0;
                            sweep_row_next  = '0;
                            sweep_last_next = lmps_pkg::ROW_W'(lmps_pkg::ROWS - 1);
                            state_next      = ST_RD;
                        end
                        default:
                        begin
                            flags_next = cmd.flags;
                        end
                    endcase
                end
            end
            ST_MASK:
            begin
                res_push     = 1'b1;
                fill_next    = (level != applied_reg);
                applied_next = level;
                if (level != applied_reg)
                begin
                    sweep_row_next  = '0;
                    sweep_last_next = lmps_pkg::ROW_W'(lmps_pkg::ROWS - 1);
                end
                else
                begin
                    sweep_row_next  = lmps_pkg::ROW_W'(lmps_pkg::LOCK_ROW_FIRST);
                    sweep_last_next = lmps_pkg::ROW_W'(lmps_pkg::LOCK_ROW_LAST);
                end
                state_next = ST_RD;
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                ram_we = 1'b1;
                if (sweep_row_reg == sweep_last_reg)
                begin
                    state_next = ST_IDLE;
                    if (is_tick_reg)
                    begin
                        if (scan_row_reg == lmps_pkg::ROW_W'(lmps_pkg::ROWS - 1))
                        begin
                            scan_row_next = '0;
                            phase_next    = (phase_reg ==
                                             lmps_pkg::BYTE_W'(lmps_pkg::LEVEL_MAX - 1)) ?
                                            '0 : phase_reg + 1'b1;
                        end
                        else
                        begin
                            scan_row_next = scan_row_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    sweep_row_next = sweep_row_reg + 1'b1;
                    state_next     = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            backlight_reg  <= '0;
            scan_row_reg   <= '0;
            phase_reg      <= '0;
            applied_reg    <= '0;
            flags_reg      <= '0;
            sweep_row_reg  <= '0;
            sweep_last_reg <= '0;
            is_tick_reg    <= 1'b0;
            fill_reg       <= 1'b0;
            row_valid_reg  <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_row_reg   <= scan_row_next;
            phase_reg      <= phase_next;
            applied_reg    <= applied_next;
            flags_reg      <= flags_next;
            sweep_row_reg  <= sweep_row_next;
            sweep_last_reg <= sweep_last_next;
            is_tick_reg    <= is_tick_next;
            fill_reg       <= fill_next;
            if (cfg_we)
            begin
                backlight_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                row_valid_reg[sweep_row_reg] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_valid_reg <= row_valid_reg[ram_raddr];
            end
        end
    end

endmodule

// ===== hdl/lmps_out_queue.sv =====
// ----------------------------------------------------------------------------
// lmps_out_queue
// small result queue that drives the result ports
// ----------------------------------------------------------------------------
module lmps_out_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_push,
    input  lmps_pkg::res_t                  res,
    output logic                            res_space,
    output logic                            empty,
    input  logic                            pop,
    output logic [lmps_pkg::OUT_ROW_W-1:0]  row_index,
    output logic [lmps_pkg::OUT_MASK_W-1:0] column_mask
);

    lmps_pkg::res_t                q_reg [lmps_pkg::QUEUE_DEPTH];
    logic [lmps_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lmps_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lmps_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          q_pop;
    lmps_pkg::res_t                head;

    assign res_space   = (count_reg != lmps_pkg::QCNT_W'(lmps_pkg::QUEUE_DEPTH));
    assign empty       = (count_reg == '0);
    assign q_pop       = pop && !empty;
    assign head        = q_reg[rd_ptr_reg];
    assign row_index   = head.row;
    assign column_mask = head.mask;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (res_push)
        begin
            wr_ptr_next = (wr_ptr_reg == lmps_pkg::QPTR_W'(lmps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lmps_pkg::QPTR_W'(lmps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (res_push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!res_push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== hdl/led_matrix_pwm_scanner.sv =====
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner
// row-multiplexed led matrix pwm scanner with lock leds and backlight level
// ----------------------------------------------------------------------------
// results: a scan tick reads its row and pushes its mask to the result queue
//   from the mask state; fade and lock requests give no result
// sweeps: a tick sweeps the lock row only, or every row on a level change; a
//   fade sweeps every row; a lock only sets the flags; each swept row is one read
//   and one write of the row-wide two-port ram; no command is taken mid-sweep
// reset: asynchronous active low; all queues empty, row, phase, level and lock
//   flags at zero, every brightness entry reads as one until its row is written
module led_matrix_pwm_scanner (
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            push,
    output logic                            full,
    input  logic [lmps_pkg::OP_W-1:0]       opcode,
    input  logic                            caps_on,
    input  logic                            num_on,
    input  logic                            scroll_on,
    // result side
    output logic                            empty,
    input  logic                            pop,
    output logic [lmps_pkg::OUT_ROW_W-1:0]  row_index,
    output logic [lmps_pkg::OUT_MASK_W-1:0] column_mask,
    // backlight level register
    input  logic                            cfg_we,
    input  logic [lmps_pkg::BYTE_W-1:0]     cfg_wdata
);

    // front to back command channel
    logic           cmd_valid;
    logic           cmd_ready;
    lmps_pkg::cmd_t cmd;

    // back to result queue
    logic           res_push;
    logic           res_space;
    lmps_pkg::res_t res;

    // front: takes requests while not full, drops the unused opcode, queues the rest
    lmps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .caps_on   (caps_on),
        .num_on    (num_on),
        .scroll_on (scroll_on),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    // back: holds the brightness ram and the scan state, sweeps rows for
    // level fills, lock led updates and fades
    lmps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_push  (res_push),
        .res       (res),
        .res_space (res_space)
    );

    // result queue: a tick starts only when a slot is free, so no push is lost
    lmps_out_queue u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_push    (res_push),
        .res         (res),
        .res_space   (res_space),
        .empty       (empty),
        .pop         (pop),
        .row_index   (row_index),
        .column_mask (column_mask)
    );

endmodule

// ===== hdl/lmps_checker.sv =====
// ----------------------------------------------------------------------------
// lmps_checker
// port-level checks of the led matrix pwm scanner
// ----------------------------------------------------------------------------
module lmps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            push,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input logic [lmps_pkg::OUT_ROW_W-1:0]  row_index,
    input logic [lmps_pkg::OUT_MASK_W-1:0] column_mask
);

    // both queues come out of a reset edge clear
    a_reset_clear: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    // a shown result names a real matrix row
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (row_index < lmps_pkg::ROWS))
        else $error("row index out of range");

    // the request side fills only by taking requests
    a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a request");

    // a waiting result holds until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(row_index) && $stable(column_mask)))
        else $error("waiting result changed");

endmodule

bind led_matrix_pwm_scanner lmps_checker u_lmps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .row_index   (row_index),
    .column_mask (column_mask)
);
